// ===== rtl/assert_macros.svh =====
// assertion helpers for the collision mask builder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define RCM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rcm check failed");

// checked on every clock edge, reset included
`define RCM_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("rcm check failed");

`endif

// ===== rtl/rcm_pkg.sv =====
package rcm_pkg;

   localparam int unsigned PLANES = 8;

   localparam logic [1:0] CMD_APPLY = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [3:0] KIND_OPAQUE      = 4'd0;
   localparam logic [3:0] KIND_TRANSPARENT = 4'd1;
   localparam logic [3:0] KIND_SKIP        = 4'd2;
   localparam logic [3:0] KIND_LEVEL_FIRST = 4'd3;
   localparam logic [3:0] KIND_LEVEL_LAST  = 4'd9;
   localparam logic [3:0] KIND_END         = 4'd10;

   localparam logic [1:0] STAT_BUILDING = 2'd0;
   localparam logic [1:0] STAT_ENDED    = 2'd1;
   localparam logic [1:0] STAT_UNKNOWN  = 2'd2;

   localparam logic CSR_TOLERANCE = 1'b0;
   localparam logic CSR_ROW_BYTES = 1'b1;

   localparam logic [7:0] TOLERANCE_RESET = 8'd0;
   localparam logic [5:0] ROW_BYTES_RESET = 6'd34;
   localparam logic [8:0] CURSOR_MAX      = 9'h1FF;
   localparam logic [7:0] BIT_MSB         = 8'h80;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  token_kind;
      logic [8:0]  run_count;
      logic [2:0]  read_plane;
      logic [13:0] read_index;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic [1:0] build_status;
      logic       range_overflow;
   } rsp_type;

   typedef struct packed {
      logic paint;
      logic read;
      logic clr;
   } bank_op_type;

   // opaque or one of the partial levels
   function automatic logic kind_is_run(input logic [3:0] kind);
      return (kind == KIND_OPAQUE) ||
             ((kind >= KIND_LEVEL_FIRST) && (kind <= KIND_LEVEL_LAST));
   endfunction

   function automatic logic [7:0] level_threshold(input logic [3:0] kind);
      logic [7:0] thr;
      case (kind)
         4'd3:    thr = 8'd237;
         4'd4:    thr = 8'd221;
         4'd5:    thr = 8'd191;
         4'd6:    thr = 8'd127;
         4'd7:    thr = 8'd63;
         4'd8:    thr = 8'd31;
         4'd9:    thr = 8'd15;
         default: thr = 8'd255;
      endcase
      return thr;
   endfunction

   function automatic logic run_is_solid(input logic [3:0] kind, input logic [7:0] tol);
      return (kind == KIND_OPAQUE) || (tol > level_threshold(kind));
   endfunction

   // saturating cursor step, msb is the overflow flag
   function automatic logic [9:0] cursor_advance(input logic [8:0] pos, input logic [8:0] cnt);
      logic [9:0] sum;
      sum = {1'b0, pos} + {1'b0, cnt};
      return sum[9] ? {1'b1, CURSOR_MAX} : {1'b0, sum[8:0]};
   endfunction

endpackage

// ===== rtl/rle_collision_mask_builder.sv =====
// Collision mask builder. One command is taken when start is high and busy is
// low; exactly one result beat follows on rsp_valid in the cycle after the
// command's last cycle, and the receiver cannot hold it off.
// Each of the eight shifted planes lives in its own single-port-read,
// single-port-write bank, and painting is a read-modify-write, forwarded
// when neighboring pixels share a byte. A solid run paints one pixel per
// cycle, all planes at once, then waits for the write-back; a read passes
// through the READ and RDOUT states; transparent, skip, end, unknown and
// suppressed tokens finish in the cycle that takes them. Clear sweeps every
// bank address, one per cycle, with PLANE_BYTES = (MAX_WIDTH/8 + 3) *
// MAX_HEIGHT (8960 at the defaults); after reset busy stays high during the
// same sweep. Configuration writes are taken only while the block is idle
// and no command is offered on start.
`include "assert_macros.svh"

module rle_collision_mask_builder #(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rcm_pkg::req_type req_item,
   output logic             rsp_valid,
   output rcm_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata
);

   localparam int unsigned PLANE_BYTES = (MAX_WIDTH / 8 + 3) * MAX_HEIGHT;
   localparam int unsigned ADDR_W      = $clog2(PLANE_BYTES);
   localparam int unsigned NPL         = rcm_pkg::PLANES;

   typedef enum logic [5:0] {
      ST_SWEEP = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_RUN   = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_READ  = 6'b010000,
      ST_RDOUT = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic              sweep_rsp_ff, sweep_rsp_in;
   logic [8:0]        cursor_x_ff, cursor_x_in;
   logic [8:0]        cursor_y_ff, cursor_y_in;
   logic [1:0]        stop_ff, stop_in;
   logic              ovf_ff, ovf_in;
   logic [8:0]        run_left_ff, run_left_in;
   logic [7:0]        tol_ff;
   logic [5:0]        row_bytes_ff;
   logic [14:0]       row_base_ff;
   logic [2:0]        read_plane_ff, read_plane_in;
   logic [ADDR_W-1:0] read_addr_ff, read_addr_in;
   logic              read_ok_ff, read_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rcm_pkg::rsp_type  rsp_item_ff, rsp_item_in;

   logic [NPL-1:0]    pix_in_range;
   logic [ADDR_W-1:0] pix_addr [NPL];
   logic [7:0]        pix_bits [NPL];
   logic [ADDR_W-1:0] bank_addr [NPL];
   logic [7:0]        bank_rd [NPL];
   rcm_pkg::bank_op_type bank_op [NPL];

   logic              emit;
   logic [7:0]        byte_out;
   logic [9:0]        adv;

   assign busy      = reset | (state_ff != ST_IDLE);
   // settings change only between commands
   assign csr_ready = ~busy & ~start;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // pixel addressing and one bank per shifted plane
   for (genvar p = 0; p < NPL; p++) begin : g_plane
      logic [9:0]  col;
      logic [15:0] idx;

      assign col = {1'b0, cursor_x_ff} + 10'd8 - 10'(p);
      assign idx = {1'b0, row_base_ff} + {9'd0, col[9:3]};
      assign pix_in_range[p] = (32'(idx) < PLANE_BYTES);
      assign pix_addr[p]     = ADDR_W'(idx);
      assign pix_bits[p]     = rcm_pkg::BIT_MSB >> col[2:0];

      always_comb begin
         bank_op[p].paint = (state_ff == ST_RUN) && pix_in_range[p];
         bank_op[p].read  = (state_ff == ST_READ);
         bank_op[p].clr   = (state_ff == ST_SWEEP);
         case (state_ff)
            ST_SWEEP: bank_addr[p] = sweep_cnt_ff;
            ST_READ:  bank_addr[p] = read_addr_ff;
            default:  bank_addr[p] = pix_addr[p];
         endcase
      end

      rcm_plane_bank #(
         .DEPTH (PLANE_BYTES)
      ) u_bank (
         .clock   (clock),
         .reset   (reset),
         .op      (bank_op[p]),
         .addr    (bank_addr[p]),
         .bits    (pix_bits[p]),
         .rd_data (bank_rd[p])
      );
   end

   always_comb begin
      state_in      = state_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      sweep_rsp_in  = sweep_rsp_ff;
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      stop_in       = stop_ff;
      ovf_in        = ovf_ff;
      run_left_in   = run_left_ff;
      read_plane_in = read_plane_ff;
      read_addr_in  = read_addr_ff;
      read_ok_in    = read_ok_ff;
      emit          = 1'b0;
      byte_out      = 8'd0;
      adv           = 10'd0;

      case (state_ff)
         ST_SWEEP: begin
            sweep_cnt_in = sweep_cnt_ff + ADDR_W'(1);
            if (sweep_cnt_ff == ADDR_W'(PLANE_BYTES - 1)) begin
               sweep_cnt_in = '0;
               sweep_rsp_in = 1'b0;
               emit         = sweep_rsp_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (req_item.command)
                  rcm_pkg::CMD_APPLY: begin
                     emit = 1'b1;
                     if (stop_ff == rcm_pkg::STAT_BUILDING) begin
                        if (rcm_pkg::kind_is_run(req_item.token_kind) &&
                            rcm_pkg::run_is_solid(req_item.token_kind, tol_ff)) begin
                           if (req_item.run_count != 9'd0) begin
                              emit        = 1'b0;
                              run_left_in = req_item.run_count;
                              state_in    = ST_RUN;
                           end
                        end else if (rcm_pkg::kind_is_run(req_item.token_kind) ||
                                     (req_item.token_kind == rcm_pkg::KIND_TRANSPARENT)) begin
                           adv         = rcm_pkg::cursor_advance(cursor_x_ff, req_item.run_count);
                           cursor_x_in = adv[8:0];
                           ovf_in      = ovf_ff | adv[9];
                        end else if (req_item.token_kind == rcm_pkg::KIND_SKIP) begin
                           adv         = rcm_pkg::cursor_advance(cursor_y_ff, req_item.run_count);
                           cursor_y_in = adv[8:0];
                           cursor_x_in = 9'd0;
                           ovf_in      = ovf_ff | adv[9];
                        end else if (req_item.token_kind == rcm_pkg::KIND_END) begin
                           stop_in = rcm_pkg::STAT_ENDED;
                        end else begin
                           stop_in = rcm_pkg::STAT_UNKNOWN;
                        end
                     end
                  end
                  rcm_pkg::CMD_READ: begin
                     read_plane_in = req_item.read_plane;
                     read_addr_in  = ADDR_W'(req_item.read_index);
                     read_ok_in    = (32'(req_item.read_index) < PLANE_BYTES);
                     state_in      = ST_READ;
                  end
                  rcm_pkg::CMD_CLEAR: begin
                     cursor_x_in  = 9'd0;
                     cursor_y_in  = 9'd0;
                     stop_in      = rcm_pkg::STAT_BUILDING;
                     ovf_in       = 1'b0;
                     sweep_cnt_in = '0;
                     sweep_rsp_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_RUN: begin
            adv         = rcm_pkg::cursor_advance(cursor_x_ff, 9'd1);
            cursor_x_in = adv[8:0];
            ovf_in      = ovf_ff | adv[9] | ~&pix_in_range;
            run_left_in = run_left_ff - 9'd1;
            if (run_left_ff == 9'd1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last write-back lands this cycle
            emit     = 1'b1;
            state_in = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_RDOUT;
         end
         ST_RDOUT: begin
            byte_out = read_ok_ff ? bank_rd[read_plane_ff] : 8'd0;
            emit     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in                = emit;
      rsp_item_in.read_byte       = byte_out;
      rsp_item_in.build_status    = stop_in;
      rsp_item_in.range_overflow  = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_cnt_ff <= '0;
         sweep_rsp_ff <= 1'b0;
         cursor_x_ff  <= 9'd0;
         cursor_y_ff  <= 9'd0;
         stop_ff      <= rcm_pkg::STAT_BUILDING;
         ovf_ff       <= 1'b0;
         run_left_ff  <= 9'd0;
         read_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= rcm_pkg::TOLERANCE_RESET;
         row_bytes_ff <= rcm_pkg::ROW_BYTES_RESET;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         sweep_rsp_ff <= sweep_rsp_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         stop_ff      <= stop_in;
         ovf_ff       <= ovf_in;
         run_left_ff  <= run_left_in;
         read_ok_ff   <= read_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rcm_pkg::CSR_TOLERANCE: tol_ff       <= csr_wdata;
               rcm_pkg::CSR_ROW_BYTES: row_bytes_ff <= csr_wdata[5:0];
               default: ;
            endcase
         end
      end
   end

   // row base is registered from cursor y; y never moves inside a run
   always_ff @(posedge clock) begin
      row_base_ff   <= 15'(row_bytes_ff) * 15'(cursor_y_ff);
      read_plane_ff <= read_plane_in;
      read_addr_ff  <= read_addr_in;
      rsp_item_ff   <= rsp_item_in;
   end

   `RCM_ASSERT_ALWAYS(a_reset_sweeps, reset |=> (state_ff == ST_SWEEP))
   `RCM_ASSERT(a_run_left_nonzero, (state_ff == ST_RUN) |-> (run_left_ff != 9'd0))
   `RCM_ASSERT(a_paint_keeps_busy, bank_op[0].paint |=> busy)
   `RCM_ASSERT(a_stopped_holds,
      (start && !busy && (req_item.command == rcm_pkg::CMD_APPLY) &&
       (stop_ff != rcm_pkg::STAT_BUILDING)) |=> ($stable(stop_ff) && rsp_valid))

endmodule

// ===== rtl/rcm_plane_bank.sv =====
module rcm_plane_bank #(
   parameter int unsigned DEPTH = 8960
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rcm_pkg::bank_op_type      op,
   input  logic [$clog2(DEPTH)-1:0]  addr,
   input  logic [7:0]                bits,
   output logic [7:0]                rd_data
);

   localparam int unsigned ADDR_W = $clog2(DEPTH);

   logic [7:0]        mem_ff [DEPTH];
   logic [7:0]        rd_data_ff;

   logic              pend_ff;
   logic              pend_in;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic [7:0]        pend_bits_ff;

   logic              last_valid_ff;
   logic              last_valid_in;
   logic [ADDR_W-1:0] last_addr_ff;
   logic [7:0]        last_data_ff;

   logic [7:0]        base;
   logic [7:0]        merged;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;

   // previous write landed after this read was issued
   assign base   = (last_valid_ff && (last_addr_ff == pend_addr_ff)) ? last_data_ff : rd_data_ff;
   assign merged = base | pend_bits_ff;

   assign wr_en   = op.clr | pend_ff;
   assign wr_addr = op.clr ? addr : pend_addr_ff;
   assign wr_data = op.clr ? 8'd0 : merged;
   assign rd_en   = op.paint | op.read;

   assign pend_in       = op.paint;
   assign last_valid_in = pend_ff & ~op.clr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 1'b0;
         last_valid_ff <= 1'b0;
      end else begin
         pend_ff       <= pend_in;
         last_valid_ff <= last_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= addr;
      pend_bits_ff <= bits;
      last_addr_ff <= pend_addr_ff;
      last_data_ff <= merged;
   end

   assign rd_data = rd_data_ff;

endmodule
